// ===== rtl/skl_pkg.sv =====
// shared types and constants of the keyframe track block
`default_nettype none
package skl_pkg;

  localparam int KEY_CAPACITY = 1024;
  localparam int KEY_AW       = $clog2(KEY_CAPACITY);
  localparam int KEY_CW       = $clog2(KEY_CAPACITY + 1);
  localparam int VAL_W        = 32;
  localparam int NUM_COMP     = 4;
  localparam int COMP_W       = $clog2(NUM_COMP);
  localparam int WORD_W       = VAL_W * (NUM_COMP + 1);

  typedef logic [NUM_COMP-1:0][VAL_W-1:0] val_arr_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_EVALUATED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_HOLD = 2'd1,
    SEL_LERP = 2'd2
  } res_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     srch_rd;
    logic     srch_upd;
    logic     sh_rd;
    logic     sh_wr;
    logic     wr_key;
    logic     ins;
    logic     rd_k0;
    logic     rd_k1;
    logic     lerp_start;
    logic     res_load;
    res_sel_e res_sel;
    status_e  res_status;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic n_zero;
    logic full;
    logic srch_done;
    logic eq;
    logic sh_done;
    logic hold;
    logic lerp_done;
    logic last_comp;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/skl_lerp.sv =====
// iterative linear interpolation unit: one multiply, bit-serial divide, round, saturate
`default_nettype none
module skl_lerp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [skl_pkg::VAL_W-1:0] v0_i,
  input  wire logic [skl_pkg::VAL_W-1:0] v1_i,
  input  wire logic [skl_pkg::VAL_W-1:0] t_i,
  input  wire logic [skl_pkg::VAL_W-1:0] t0_i,
  input  wire logic [skl_pkg::VAL_W-1:0] t1_i,
  output logic                           done_o,
  output logic      [skl_pkg::VAL_W-1:0] res_o
);
  import skl_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_RND, L_SUM} lst_e;

  lst_e        state_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [31:0] md_q, mn_q, den_q, v0_q, rem_q, res_q;
  logic        neg_q;
  logic [63:0] p_q;
  logic [33:0] qc_q;

  logic [32:0] d, num, dn, numn, rem2, rsub;
  logic [31:0] md, mn;
  logic        ge, rnd_up;
  logic [64:0] qr;
  logic [33:0] qc;
  logic [35:0] sum;
  logic [31:0] sat;

  // operand magnitudes and sign
  always_comb begin
    d    = {v1_i[31], v1_i} - {v0_i[31], v0_i};
    num  = {1'b0, t_i} - {1'b0, t0_i};
    dn   = -d;
    numn = -num;
    md   = d[32] ? dn[31:0] : d[31:0];
    mn   = num[32] ? numn[31:0] : num[31:0];
  end

  // one restoring divide step
  always_comb begin
    rem2 = {rem_q, p_q[63]};
    ge   = rem2 >= {1'b0, den_q};
    rsub = rem2 - {1'b0, den_q};
  end

  // round to nearest, ties away, and clamp
  always_comb begin
    rnd_up = ({rem_q, 1'b0} >= {1'b0, den_q}) && (rem_q != 32'd0);
    qr     = {1'b0, p_q} + {64'd0, rnd_up};
    qc     = (qr > 65'h2_0000_0000) ? 34'h2_0000_0000 : qr[33:0];
  end

  // add to the start value and saturate
  always_comb begin
    if (neg_q) begin
      sum = {{4{v0_q[31]}}, v0_q} - {2'b00, qc_q};
    end else begin
      sum = {{4{v0_q[31]}}, v0_q} + {2'b00, qc_q};
    end
    if (!sum[35] && (sum[34:31] != 4'd0)) begin
      sat = 32'h7fff_ffff;
    end else if (sum[35] && (sum[34:31] != 4'hf)) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) state_q <= L_MUL;
        end
        L_MUL: begin
          cnt_q   <= '0;
          state_q <= L_DIV;
        end
        L_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= L_RND;
        end
        L_RND: state_q <= L_SUM;
        L_SUM: begin
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          md_q  <= md;
          mn_q  <= mn;
          neg_q <= d[32] ^ num[32];
          den_q <= t1_i - t0_i;
          v0_q  <= v0_i;
        end
      end
      L_MUL: begin
        p_q   <= md_q * mn_q;
        rem_q <= '0;
      end
      L_DIV: begin
        rem_q <= ge ? rsub[31:0] : rem2[31:0];
        p_q   <= {p_q[62:0], ge};
      end
      L_RND: qc_q <= qc;
      L_SUM: res_q <= sat;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== rtl/skl_dpath.sv =====
// datapath: key memory, search and shift indexes, interpolation and result register
`default_nettype none
module skl_dpath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire skl_pkg::ctl_cmd_t         cmd_i,
  output skl_pkg::dp_stat_t              stat_o,
  input  wire logic [skl_pkg::VAL_W-1:0] in_time_i,
  input  wire skl_pkg::val_arr_t         in_val_i,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output skl_pkg::status_e               out_status_o,
  output skl_pkg::val_arr_t              out_val_o
);
  import skl_pkg::*;

  logic [WORD_W-1:0] mem_q [KEY_CAPACITY];
  logic [WORD_W-1:0] rdata_q, key0_q, wdata;
  logic [KEY_AW-1:0] raddr, waddr;
  logic              re, we;

  logic [VAL_W-1:0]  t_q;
  val_arr_t          val_q, res_q, out_val_q;
  logic [KEY_CW-1:0] n_q, lo_q, hi_q, j_q;
  logic              eq_q;
  logic [COMP_W-1:0] comp_q;
  logic              out_valid_q;
  status_e           out_status_q;

  logic [KEY_CW:0]   mid_sum;
  logic [KEY_CW-1:0] mid, k0, k1, jm1;
  logic [VAL_W-1:0]  rd_time, lerp_res;
  val_arr_t          rd_val, k0_val;
  logic              lerp_done;

  assign rd_time = rdata_q[VAL_W-1:0];
  assign rd_val  = rdata_q[WORD_W-1:VAL_W];
  assign k0_val  = key0_q[WORD_W-1:VAL_W];

  // index arithmetic
  always_comb begin
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[KEY_CW:1];
    k0      = (lo_q == '0) ? '0 : lo_q - KEY_CW'(1);
    k1      = k0 + KEY_CW'(1);
    jm1     = j_q - KEY_CW'(1);
  end

  // memory port selection
  always_comb begin
    re    = cmd_i.srch_rd | cmd_i.sh_rd | cmd_i.rd_k0 | cmd_i.rd_k1;
    raddr = mid[KEY_AW-1:0];
    if (cmd_i.sh_rd) raddr = jm1[KEY_AW-1:0];
    if (cmd_i.rd_k0) raddr = k0[KEY_AW-1:0];
    if (cmd_i.rd_k1) raddr = k1[KEY_AW-1:0];
    we    = cmd_i.sh_wr | cmd_i.wr_key;
    waddr = cmd_i.sh_wr ? j_q[KEY_AW-1:0] : lo_q[KEY_AW-1:0];
    wdata = cmd_i.sh_wr ? rdata_q : {val_q, t_q};
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // item and key registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q   <= in_time_i;
      val_q <= in_val_i;
    end
    if (cmd_i.rd_k1) key0_q <= rdata_q;
    if (lerp_done) res_q[comp_q] <= lerp_res;
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        SEL_HOLD: out_val_q <= rd_val;
        SEL_LERP: out_val_q <= res_q;
        default:  out_val_q <= '0;
      endcase
      out_status_q <= cmd_i.res_status;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      j_q         <= '0;
      eq_q        <= 1'b0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lo_q   <= '0;
        hi_q   <= n_q;
        j_q    <= n_q;
        eq_q   <= 1'b0;
        comp_q <= '0;
      end
      // binary search step on the returned key time
      if (cmd_i.srch_upd) begin
        if (rd_time < t_q) begin
          lo_q <= mid + KEY_CW'(1);
        end else begin
          hi_q <= mid;
          eq_q <= (rd_time == t_q);
        end
      end
      if (cmd_i.sh_wr) j_q <= jm1;
      if (cmd_i.wr_key && cmd_i.ins) n_q <= n_q + KEY_CW'(1);
      if (lerp_done) comp_q <= comp_q + COMP_W'(1);
      // result register
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  skl_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.lerp_start),
    .v0_i    (k0_val[comp_q]),
    .v1_i    (rd_val[comp_q]),
    .t_i     (t_q),
    .t0_i    (key0_q[VAL_W-1:0]),
    .t1_i    (rd_time),
    .done_o  (lerp_done),
    .res_o   (lerp_res)
  );

  always_comb begin
    stat_o.n_zero    = (n_q == '0);
    stat_o.full      = (n_q == KEY_CW'(KEY_CAPACITY));
    stat_o.srch_done = (lo_q == hi_q);
    stat_o.eq        = eq_q;
    stat_o.sh_done   = (j_q == lo_q);
    stat_o.hold      = (k1 >= n_q);
    stat_o.lerp_done = lerp_done;
    stat_o.last_comp = (comp_q == COMP_W'(NUM_COMP - 1));
    stat_o.out_busy  = out_valid_q;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_val_o    = out_val_q;

endmodule
`default_nettype wire

// ===== rtl/skl_ctrl.sv =====
// controller state machine sequencing search, shift, write and interpolation
`default_nettype none
module skl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_func_i,
  output logic                   in_ready_o,
  input  wire skl_pkg::dp_stat_t stat_i,
  output skl_pkg::ctl_cmd_t      cmd_o
);
  import skl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SET_DEC, S_SH_RD, S_SH_WR, S_WR_KEY,
    S_EV_DEC, S_RD_K1, S_LERP_GO, S_LERP_WAIT, S_RESP
  } state_e;

  state_e   state_q, state_d;
  logic     func_q, func_d;
  status_e  status_q, status_d;
  res_sel_e sel_q, sel_d;
  logic     accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // next state and command decode
  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    status_d = status_q;
    sel_d    = sel_q;
    cmd_o    = '0;
    cmd_o.res_sel    = sel_q;
    cmd_o.res_status = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          func_d     = in_func_i;
          if (in_func_i && stat_i.n_zero) begin
            status_d = ST_EMPTY;
            sel_d    = SEL_ZERO;
            state_d  = S_RESP;
          end else begin
            state_d = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (stat_i.srch_done) begin
          state_d = func_q ? S_EV_DEC : S_SET_DEC;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = S_SRCH_RD;
      end
      S_SET_DEC: begin
        sel_d = SEL_ZERO;
        if (stat_i.eq) begin
          status_d = ST_REPLACED;
          state_d  = S_WR_KEY;
        end else if (stat_i.full) begin
          status_d = ST_FULL;
          state_d  = S_RESP;
        end else begin
          status_d = ST_INSERTED;
          state_d  = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.sh_done) begin
          state_d = S_WR_KEY;
        end else begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SH_RD;
      end
      S_WR_KEY: begin
        cmd_o.wr_key = 1'b1;
        cmd_o.ins    = (status_q == ST_INSERTED);
        state_d      = S_RESP;
      end
      S_EV_DEC: begin
        status_d    = ST_EVALUATED;
        cmd_o.rd_k0 = 1'b1;
        if (stat_i.hold) begin
          sel_d   = SEL_HOLD;
          state_d = S_RESP;
        end else begin
          sel_d   = SEL_LERP;
          state_d = S_RD_K1;
        end
      end
      S_RD_K1: begin
        cmd_o.rd_k1 = 1'b1;
        state_d     = S_LERP_GO;
      end
      S_LERP_GO: begin
        cmd_o.lerp_start = 1'b1;
        state_d          = S_LERP_WAIT;
      end
      S_LERP_WAIT: begin
        if (stat_i.lerp_done) begin
          state_d = stat_i.last_comp ? S_RESP : S_LERP_GO;
        end
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered decisions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      func_q   <= 1'b0;
      status_q <= ST_INSERTED;
      sel_q    <= SEL_ZERO;
    end else begin
      state_q  <= state_d;
      func_q   <= func_d;
      status_q <= status_d;
      sel_q    <= sel_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_keyframe_table_lerp.sv =====
// top level of the sorted keyframe track with linear interpolation
// one track of up to 1024 keys kept sorted by time, each key a time and four values
// input stream: tuser selects set key (0) or evaluate (1); tdata carries time and values
// output stream: exactly one result per item; tuser carries the status code,
//   tdata the four evaluated values (zero for set items and an empty track)
// one item is processed at a time; the key memory has one read and one write port
// a binary search step reads the middle key, then narrows the range on its time
// set: search, then each key above the insert point is moved up one place, then
//   the key is written (no shift for a replace, no write for a full track)
// evaluate: search, then the shared multiply and bit-serial 64-step divider work
//   through the four components in turn; holding the last key skips the divider
// the result sits in an output register; a new item is taken as soon as the
//   controller returns to idle, and when the receiver stalls the controller waits
//   with its next result until the register empties
// reset empties the track; the key memory itself is not cleared
`default_nettype none
module sorted_keyframe_table_lerp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [159:0] s_axis_tdata,  // time_req, value_0, value_1, value_2, value_3
  input  wire logic [0:0]   s_axis_tuser,  // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // out_0, out_1, out_2, out_3
  output logic [2:0]        m_axis_tuser   // status
);
  import skl_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  status_e  out_status;
  val_arr_t in_val, out_val;

  assign in_val       = s_axis_tdata[159:32];
  assign m_axis_tdata = out_val;
  assign m_axis_tuser = out_status;

  skl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skl_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_time_i    (s_axis_tdata[31:0]),
    .in_val_i     (in_val),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_val_o    (out_val)
  );

endmodule
`default_nettype wire

// ===== verif/tb_sorted_keyframe_table_lerp.sv =====
// testbench of the sorted keyframe track: directed and random set/evaluate traffic
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_keyframe_table_lerp;
  import skl_pkg::*;

  localparam int  HALF_PERIOD = 10;
  localparam int  RAND_ITEMS  = 540;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct {
    status_e     status;
    logic [31:0] vals[4];
  } track_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // time_req, value_0, value_1, value_2, value_3
  logic [0:0]   s_axis_tuser = '0;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // out_0, out_1, out_2, out_3
  logic [2:0]   m_axis_tuser;        // status

  // shadow copy of the track
  logic [31:0]  key_time[KEY_CAPACITY];
  logic [31:0]  key_val[KEY_CAPACITY][4];
  int           key_num = 0;

  track_result_t pending_results[$];
  int     fail_count = 0;
  longint cycle_count = 0;
  bit     no_idle = 1'b0;
  int     recv_stall = 0;

  sorted_keyframe_table_lerp u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // one signed component: v0 + round((v1 - v0) * num / den), saturated
  function automatic logic [31:0] lerp_comp(logic [31:0] a, logic [31:0] b,
                                            longint num, longint unsigned den);
    longint v0, d, res;
    bit neg;
    longint unsigned md, mn, p, q, r;
    v0 = longint'(signed'(a));
    d = longint'(signed'(b)) - v0;
    neg = (d < 0) != (num < 0);
    md = (d < 0) ? -d : d;
    mn = (num < 0) ? -num : num;
    p = md * mn;
    q = p / den;
    r = p % den;
    if (r != 0 && r * 2 >= den) q++;
    if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
    res = neg ? v0 - longint'(q) : v0 + longint'(q);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // update the shadow track and work out the result of one item
  function automatic track_result_t apply_item(logic func, logic [31:0] t,
                                               logic [31:0] v[4]);
    track_result_t res;
    int idx, k0;
    longint num;
    longint unsigned den;
    foreach (res.vals[i]) res.vals[i] = '0;
    if (func == FUNC_SET) begin
      idx = 0;
      while (idx < key_num && key_time[idx] < t) idx++;
      if (idx < key_num && key_time[idx] == t) begin
        res.status = ST_REPLACED;
      end else if (key_num < KEY_CAPACITY) begin
        for (int j = key_num; j > idx; j--) begin
          key_time[j] = key_time[j-1];
          key_val[j] = key_val[j-1];
        end
        key_time[idx] = t;
        key_num++;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
        return res;
      end
      key_val[idx] = v;
      return res;
    end
    if (key_num == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    res.status = ST_EVALUATED;
    k0 = 0;
    while (k0 + 1 < key_num && key_time[k0+1] < t) k0++;
    if (k0 + 1 >= key_num) begin
      res.vals = key_val[k0];
      return res;
    end
    num = longint'(t) - longint'(key_time[k0]);
    den = longint'(key_time[k0+1]) - longint'(key_time[k0]);
    for (int i = 0; i < 4; i++)
      res.vals[i] = lerp_comp(key_val[k0][i], key_val[k0+1][i], num, den);
    return res;
  endfunction

  // send one item, with an optional idle burst first
  task automatic send_item(logic func, logic [31:0] t, logic [31:0] v[4]);
    int gap;
    gap = (!no_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser = func;
    s_axis_tdata = {v[3], v[2], v[1], v[0], t};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_item(func, t, v));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic set_key(logic [31:0] t, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [31:0] d);
    logic [31:0] v[4];
    v = '{a, b, c, d};
    send_item(FUNC_SET, t, v);
  endtask

  // evaluate, with junk in the value fields since they are ignored
  task automatic eval_at(logic [31:0] t);
    logic [31:0] v[4];
    v = '{$urandom, $urandom, $urandom, $urandom};
    send_item(FUNC_EVAL, t, v);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // empty track, single key, extrapolation, saturation, extremes of time
  task automatic test_directed();
    eval_at(32'h0000_0000);
    eval_at(32'hffff_ffff);
    set_key(32'h0005_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000);
    eval_at(32'h0000_0000);
    eval_at(32'h0005_0000);
    eval_at(32'hffff_ffff);
    set_key(32'h000a_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0003_0000, 32'h0000_0001);
    eval_at(32'h0007_8000);
    eval_at(32'h0006_0000);
    eval_at(32'h0000_0000);
    eval_at(32'h0005_0001);
    set_key(32'h0005_0000, 32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0002_0000);
    eval_at(32'h0000_0001);
    eval_at(32'h0009_ffff);
    set_key(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    set_key(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    eval_at(32'h0000_0000);
    eval_at(32'h8000_0000);
    eval_at(32'hffff_fffe);
    eval_at(32'hffff_ffff);
    wait_drained();
  endtask

  // random sets and evaluates over a small pool of times so replaces occur
  task automatic test_random();
    logic [31:0] t;
    logic [31:0] v[4];
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) wait_drained();
      t = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 95) << 14);
      v = '{rand_value(), rand_value(), rand_value(), rand_value()};
      send_item(($urandom_range(0, 9) < 4) ? FUNC_SET : FUNC_EVAL, t, v);
    end
    wait_drained();
  endtask

  // fill the track just below the top key, then a full-track drop and replace
  task automatic test_full_track();
    logic [31:0] t;
    no_idle = 1'b1;
    t = 32'hffff_fffe;
    while (key_num < KEY_CAPACITY) begin
      set_key(t, $urandom, $urandom, $urandom, $urandom);
      t--;
    end
    set_key(32'h0000_0000 + t, 32'h1, 32'h2, 32'h3, 32'h4);
    set_key(key_time[KEY_CAPACITY/2], 32'h5, 32'h6, 32'h7, 32'h8);
    eval_at(key_time[KEY_CAPACITY/2] + 32'h1);
    eval_at(32'hffff_ffff);
    eval_at(32'h0000_0000);
    eval_at($urandom);
    wait_drained();
  endtask

  // receiver stalls in random bursts
  always @(negedge clk_i) begin
    if (no_idle) begin
      m_axis_tready = 1'b1;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 11);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    track_result_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer status %0d", m_axis_tuser);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, m_axis_tuser);
          fail_count++;
        end
        for (int i = 0; i < 4; i++)
          if (m_axis_tdata[32*i +: 32] !== exp_res.vals[i]) begin
            $error("out_%0d: expected %h actual %h", i, exp_res.vals[i],
                   m_axis_tdata[32*i +: 32]);
            fail_count++;
          end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_full_track();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
